// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands sampled on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/msg_pkg.sv =====
// ----------------------------------------------------------------------------
// msg_pkg
// shared types, widths and constants of the mode-select gain block
// ----------------------------------------------------------------------------
`default_nettype none

package msg_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int CTRL_W      = 16;
   localparam int GAIN_W      = 32;
   localparam int FRAC_W      = 28;
   localparam int TGT_SHIFT   = 16;

   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DIV_N_W   = 45;
   localparam int DIV_D_W   = 19;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam int RECIP_TEN   = 52429;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_Q_W   = 14;

   localparam logic signed [GAIN_W-1:0] ONE_Q28      = 32'sh1000_0000;
   localparam logic signed [GAIN_W-1:0] HALF_Q28     = 32'sh0800_0000;
   localparam logic signed [GAIN_W-1:0] NEG_HALF_Q28 = -32'sh0800_0000;

   localparam logic [CTRL_W:0]    UNITY_Q16      = 17'h1_0000;
   localparam logic [CTRL_W:0]    SCALE_MIN      = 17'd52429;
   localparam logic [CTRL_W:0]    GATE_KNEE      = 17'h0_4000;
   localparam logic [DIV_N_W-1:0] COMP_NUM_BASE  = 45'h1000_0000_8000;
   localparam logic [DIV_D_W-1:0] COMP_DEN_BASE  = 19'h1_0000;
   localparam logic [CTRL_W-1:0]  RAMP_STEPS_RST = 16'd480;

   localparam logic [1:0] MODE_GATE     = 2'd0;
   localparam logic [1:0] MODE_EXPAND   = 2'd1;
   localparam logic [1:0] MODE_COMPRESS = 2'd2;
   localparam logic [1:0] MODE_INVERT   = 2'd3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_FUNCTION_AMOUNT = 2'd0;
   localparam csr_index_type CSR_SUSTAIN_CUT     = 2'd1;
   localparam csr_index_type CSR_RAMP_STEPS      = 2'd2;

   typedef struct packed {
      logic [CTRL_W-1:0]             intensity;
      logic [CTRL_W-1:0]             density;
      logic signed [SAMPLE_BITS-1:0] sample_ch0;
      logic signed [SAMPLE_BITS-1:0] sample_ch1;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_ch0;
      logic signed [SAMPLE_BITS-1:0] out_ch1;
      logic signed [GAIN_W-1:0]      gain_now;
   } rsp_word_type;

   // sample times Q4.28 gain, round half up, saturate to sample width
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [MUL_P_W-1:0] prod);
      logic signed [MUL_P_W:0]                 sum;
      logic signed [MUL_P_W-FRAC_W:0]          sh;
      logic [MUL_P_W-FRAC_W-SAMPLE_BITS+1:0]   hi;
      logic signed [SAMPLE_BITS-1:0]           res;
      sum = (MUL_P_W + 1)'(prod) + (MUL_P_W + 1)'(1 << (FRAC_W - 1));
      sh  = sum[MUL_P_W:FRAC_W];
      hi  = sh[MUL_P_W-FRAC_W:SAMPLE_BITS-1];
      if ((&hi) || !(|hi)) begin
         res = sh[SAMPLE_BITS-1:0];
      end else if (sh[MUL_P_W-FRAC_W]) begin
         res = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msg_div.sv =====
// ----------------------------------------------------------------------------
// msg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module msg_div import msg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] num,
   input  wire logic [DIV_D_W-1:0] den,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quo
);

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   den_ff;

   logic [DIV_D_W:0]     shifted_in;
   logic [DIV_D_W+1:0]   trial_in;
   logic                 fits_in;

   always_comb begin
      shifted_in = {rem_ff, quo_ff[DIV_N_W-1]};
      trial_in   = {1'b0, shifted_in} - {2'b00, den_ff};
      fits_in    = !trial_in[DIV_D_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= DIV_CNT_W'(DIV_N_W);
            quo_ff <= num;
            rem_ff <= '0;
            den_ff <= den;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            quo_ff <= {quo_ff[DIV_N_W-2:0], fits_in};
            rem_ff <= fits_in ? trial_in[DIV_D_W-1:0] : shifted_in[DIV_D_W-1:0];
            if (cnt_ff == DIV_CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/msg_mul.sv =====
// ----------------------------------------------------------------------------
// msg_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module msg_mul import msg_pkg::*; (
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] op_a,
   input  wire logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0]      prod
);

   logic signed [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mode_select_gain_with_ramp_smoothing_unit.sv =====
// ----------------------------------------------------------------------------
// mode_select_gain_with_ramp_smoothing_unit
// sequence: scale, law, target, ramp update, ramp advance, sample multiplies,
//   output; compression law and new ramp start each wait on the serial divider
// flow: a new word is taken only once the last result word is loaded; one
//   shared multiplier and one bit-serial divider are reused under the sequencer
// reset: synchronous; gain and target 1.0, no ramp, ramp_steps 480
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mode_select_gain_with_ramp_smoothing_unit import msg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_word_type       rsp_word,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [CTRL_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_LAW, ST_LAW_DIV, ST_TGT, ST_TGT_W,
      ST_UPD, ST_RAMP_DIV, ST_ADV, ST_MUL0, ST_MUL1, ST_OUT
   } state_type;

   state_type state_ff;

   logic [CTRL_W-1:0] fa_ff;
   logic [CTRL_W-1:0] cut_ff;
   logic [CTRL_W-1:0] steps_ff;

   logic signed [GAIN_W-1:0] cur_ff;
   logic signed [GAIN_W-1:0] target_ff;
   logic signed [GAIN_W-1:0] step_ff;
   logic [CTRL_W-1:0]        ramp_left_ff;

   logic [CTRL_W-1:0]             inten_ff;
   logic [CTRL_W-1:0]             dens_ff;
   logic signed [SAMPLE_BITS-1:0] s0_ff;
   logic signed [SAMPLE_BITS-1:0] s1_ff;
   logic [CTRL_W:0]               scale_ff;
   logic signed [GAIN_W-1:0]      law_ff;
   logic signed [GAIN_W-1:0]      tgt_ff;
   logic                          ramp_neg_ff;
   logic signed [SAMPLE_BITS-1:0] out0_ff;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_prod;

   logic               div_start;
   logic [DIV_N_W-1:0] div_num;
   logic [DIV_D_W-1:0] div_den;
   logic               div_done;
   logic [DIV_N_W-1:0] div_quo;

   logic                     compress_in;
   logic                     gate_open_in;
   logic [CTRL_W+1:0]        inv_mul_in;
   logic signed [GAIN_W-1:0] inv_gain_in;
   logic signed [GAIN_W-1:0] law_in;
   logic [CTRL_W:0]          scale_in;
   logic signed [GAIN_W:0]   diff_in;
   logic [GAIN_W:0]          mag_in;
   logic                     new_tgt_in;
   logic signed [GAIN_W-1:0] step_in;

   msg_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   msg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // gain laws
   always_comb begin
      compress_in  = (fa_ff[CTRL_W-1:CTRL_W-2] == MODE_COMPRESS);
      gate_open_in = {inten_ff, 1'b0} > (GATE_KNEE - {1'b0, fa_ff});
      inv_mul_in   = {1'b0, inten_ff, 1'b0} + {2'b00, inten_ff};
      inv_gain_in  = ONE_Q28 - signed'(GAIN_W'({inv_mul_in, 11'b0}));
      if (inv_gain_in < NEG_HALF_Q28) begin
         inv_gain_in = NEG_HALF_Q28;
      end
      unique case (fa_ff[CTRL_W-1:CTRL_W-2])
         MODE_GATE: begin
            law_in = gate_open_in ? ONE_Q28
                   : signed'(GAIN_W'({UNITY_Q16 - {1'b0, cut_ff}, 12'b0}));
         end
         MODE_EXPAND:   law_in = HALF_Q28 + signed'(GAIN_W'({inten_ff, 13'b0}));
         MODE_COMPRESS: law_in = '0;
         MODE_INVERT:   law_in = inv_gain_in;
         default:       law_in = '0;
      endcase
      scale_in = UNITY_Q16 - (CTRL_W + 1)'(mul_prod[RECIP_SHIFT +: RECIP_Q_W]);
   end

   // ramp start
   always_comb begin
      diff_in    = (GAIN_W + 1)'(tgt_ff) - (GAIN_W + 1)'(cur_ff);
      mag_in     = diff_in[GAIN_W] ? unsigned'(-diff_in) : unsigned'(diff_in);
      new_tgt_in = (tgt_ff != target_ff);
      step_in    = ramp_neg_ff ? -signed'(div_quo[GAIN_W-1:0])
                               : signed'(div_quo[GAIN_W-1:0]);
   end

   // shared unit operand select
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         ST_SCALE: begin
            mul_a = MUL_A_W'({dens_ff, 1'b0}) + MUL_A_W'(5);
            mul_b = MUL_B_W'(RECIP_TEN);
         end
         ST_LAW: begin
            div_start = compress_in;
            div_num   = COMP_NUM_BASE + DIV_N_W'({inten_ff, 1'b0});
            div_den   = COMP_DEN_BASE + DIV_D_W'({inten_ff, 2'b00});
         end
         ST_TGT: begin
            mul_a = MUL_A_W'(law_ff);
            mul_b = MUL_B_W'({1'b0, scale_ff});
         end
         ST_UPD: begin
            div_start = new_tgt_in && (steps_ff != '0);
            div_num   = DIV_N_W'(mag_in);
            div_den   = DIV_D_W'(steps_ff);
         end
         ST_MUL0: begin
            mul_a = MUL_A_W'(cur_ff);
            mul_b = MUL_B_W'(s0_ff);
         end
         ST_MUL1, ST_OUT: begin
            mul_a = MUL_A_W'(cur_ff);
            mul_b = MUL_B_W'(s1_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fa_ff        <= '0;
         cut_ff       <= '0;
         steps_ff     <= RAMP_STEPS_RST;
         cur_ff       <= ONE_Q28;
         target_ff    <= ONE_Q28;
         step_ff      <= '0;
         ramp_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FUNCTION_AMOUNT: fa_ff    <= csr_data;
               CSR_SUSTAIN_CUT:     cut_ff   <= csr_data;
               CSR_RAMP_STEPS:      steps_ff <= csr_data;
               default:             ;
            endcase
         end
         // the output state reloads the result register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  inten_ff <= req_word.intensity;
                  dens_ff  <= req_word.density;
                  s0_ff    <= req_word.sample_ch0;
                  s1_ff    <= req_word.sample_ch1;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: state_ff <= ST_LAW;
            ST_LAW: begin
               scale_ff <= scale_in;
               law_ff   <= law_in;
               state_ff <= compress_in ? ST_LAW_DIV : ST_TGT;
            end
            ST_LAW_DIV: begin
               if (div_done) begin
                  law_ff   <= signed'(div_quo[GAIN_W-1:0]);
                  state_ff <= ST_TGT;
               end
            end
            ST_TGT: state_ff <= ST_TGT_W;
            ST_TGT_W: begin
               tgt_ff   <= mul_prod[TGT_SHIFT +: GAIN_W];
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               ramp_neg_ff <= diff_in[GAIN_W];
               state_ff    <= ST_ADV;
               if (new_tgt_in) begin
                  target_ff <= tgt_ff;
                  if (steps_ff == '0) begin
                     cur_ff       <= tgt_ff;
                     ramp_left_ff <= '0;
                  end else begin
                     ramp_left_ff <= steps_ff;
                     state_ff     <= ST_RAMP_DIV;
                  end
               end
            end
            ST_RAMP_DIV: begin
               if (div_done) begin
                  step_ff  <= step_in;
                  state_ff <= ST_ADV;
               end
            end
            ST_ADV: begin
               if (ramp_left_ff != '0) begin
                  ramp_left_ff <= ramp_left_ff - CTRL_W'(1);
                  if (ramp_left_ff != CTRL_W'(1)) begin
                     cur_ff <= cur_ff + step_ff;
                  end else begin
                     cur_ff <= target_ff;
                  end
               end
               state_ff <= ST_MUL0;
            end
            ST_MUL0: state_ff <= ST_MUL1;
            ST_MUL1: begin
               out0_ff  <= round_sat(mul_prod);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_word_ff.out_ch0  <= out0_ff;
                  rsp_word_ff.out_ch1  <= round_sat(mul_prod);
                  rsp_word_ff.gain_now <= cur_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_IMP(a_div_done_waited, div_done,
      (state_ff == ST_LAW_DIV) || (state_ff == ST_RAMP_DIV))
   `ASSERT_NXT(a_ramp_lands, (state_ff == ST_ADV) && (ramp_left_ff == CTRL_W'(1)),
      cur_ff == target_ff)
   `ASSERT_IMP(a_scale_range, state_ff == ST_TGT, scale_ff >= SCALE_MIN)
   `ASSERT_IMP(a_ramp_div_nonzero, state_ff == ST_RAMP_DIV, steps_ff != '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the mode-select gain block with ramp smoothing. A directed table
// walks every gain law, the gate threshold edges, ramp start, continuation,
// ramp length changes and the ignored register index, then random phases
// change all registers and drive frames on both channels, with random gaps
// unless steady. Each result word is checked against its typed table word or
// an in-bench model of gain laws, density scaling, ramp smoother, saturation.
// ----------------------------------------------------------------------------
module tb_top import msg_pkg::*; ();

   localparam csr_index_type CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASES = 12;
   localparam int WORDS_PER_PHASE = 80;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

   typedef enum logic {STEP_WORD, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic              typed;
      csr_index_type     idx;
      logic [CTRL_W-1:0] data;
      req_word_type      word;
      rsp_word_type      frame;
   } plan_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_word_type  req_word;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_word_type  rsp_word;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [CTRL_W-1:0] csr_data;

   // model state
   logic [CTRL_W-1:0]        fa_reg;
   logic [CTRL_W-1:0]        cut_reg;
   logic [CTRL_W-1:0]        steps_reg;
   logic signed [GAIN_W-1:0] cur_gain;
   logic signed [GAIN_W-1:0] tgt_gain;
   logic signed [GAIN_W-1:0] ramp_inc;
   logic [CTRL_W-1:0]        ramp_count;

   rsp_word_type frames_due[$];
   plan_row_type plan[$];
   int           mismatches;

   mode_select_gain_with_ramp_smoothing_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("tb_top: errors");
      $finish;
   end

   function automatic longint law_gain_q28(input logic [CTRL_W-1:0] inten);
      longint i;
      longint den;
      longint g;
      i = longint'(inten);
      g = 0;
      case (fa_reg[CTRL_W-1:CTRL_W-2])
         MODE_GATE: begin
            if (2 * i > 16384 - longint'(fa_reg)) g = longint'(ONE_Q28);
            else g = (65536 - longint'(cut_reg)) <<< 12;
         end
         MODE_EXPAND: begin
            g = longint'(HALF_Q28) + (i <<< 13);
         end
         MODE_COMPRESS: begin
            den = 65536 + 4 * i;
            g = ((longint'(1) <<< 44) + den / 2) / den;
         end
         MODE_INVERT: begin
            g = longint'(ONE_Q28) - i * 6144;
            if (g < longint'(NEG_HALF_Q28)) g = longint'(NEG_HALF_Q28);
         end
      endcase
      return g;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
      input logic signed [SAMPLE_BITS-1:0] s,
      input logic signed [GAIN_W-1:0] g);
      longint p;
      p = (longint'(s) * longint'(g) + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      if (p > SAMPLE_MAX) p = SAMPLE_MAX;
      else if (p < SAMPLE_MIN) p = SAMPLE_MIN;
      return SAMPLE_BITS'(p);
   endfunction

   function automatic rsp_word_type smooth_and_scale(input req_word_type w);
      longint scale;
      longint prod;
      logic signed [GAIN_W-1:0] tgt;
      rsp_word_type f;
      scale = 65536 - (2 * longint'(w.density) + 5) / 10;
      prod = law_gain_q28(w.intensity) * scale;
      tgt = GAIN_W'(prod >>> TGT_SHIFT);
      if (tgt != tgt_gain) begin
         if (steps_reg == 0) begin
            cur_gain = tgt;
            tgt_gain = tgt;
            ramp_count = '0;
         end else begin
            tgt_gain = tgt;
            ramp_count = steps_reg;
            ramp_inc = GAIN_W'((longint'(tgt) - longint'(cur_gain)) / longint'(steps_reg));
         end
      end
      if (ramp_count != 0) begin
         ramp_count = ramp_count - CTRL_W'(1);
         if (ramp_count != 0) cur_gain = cur_gain + ramp_inc;
         else cur_gain = tgt_gain;
      end
      f.out_ch0 = scale_sample(w.sample_ch0, cur_gain);
      f.out_ch1 = scale_sample(w.sample_ch1, cur_gain);
      f.gain_now = cur_gain;
      return f;
   endfunction

   function automatic void plan_csr(input csr_index_type idx, input int v);
      plan_row_type r;
      r = '0;
      r.kind = STEP_CSR;
      r.idx = idx;
      r.data = CTRL_W'(v);
      plan.push_back(r);
   endfunction

   function automatic void plan_word(input int i, input int d, input int s0, input int s1);
      plan_row_type r;
      r = '0;
      r.kind = STEP_WORD;
      r.word.intensity = CTRL_W'(i);
      r.word.density = CTRL_W'(d);
      r.word.sample_ch0 = SAMPLE_BITS'(s0);
      r.word.sample_ch1 = SAMPLE_BITS'(s1);
      plan.push_back(r);
   endfunction

   function automatic void plan_check(input int i, input int d, input int s0, input int s1,
                                      input int o0, input int o1, input int g);
      plan_row_type r;
      plan_word(i, d, s0, s1);
      r = plan.pop_back();
      r.typed = 1'b1;
      r.frame.out_ch0 = SAMPLE_BITS'(o0);
      r.frame.out_ch1 = SAMPLE_BITS'(o1);
      r.frame.gain_now = GAIN_W'(g);
      plan.push_back(r);
   endfunction

   function automatic logic [CTRL_W-1:0] pick_amount();
      if ($urandom_range(0, 1) == 0) return CTRL_W'($urandom);
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h3FFF;
         2: return 16'h4000;
         3: return 16'h7FFF;
         4: return 16'h8000;
         5: return 16'hBFFF;
         6: return 16'hC000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [CTRL_W-1:0] pick_cut();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 45) return '1;
      return CTRL_W'($urandom);
   endfunction

   function automatic logic [CTRL_W-1:0] pick_steps();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 75) return CTRL_W'($urandom_range(1, 6));
      if (r < 95) return CTRL_W'($urandom_range(7, 40));
      return CTRL_W'($urandom);
   endfunction

   function automatic logic [CTRL_W-1:0] pick_intensity();
      int r;
      r = $urandom_range(0, 99);
      // hit the gate threshold from both sides
      if (fa_reg[CTRL_W-1:CTRL_W-2] == MODE_GATE && r < 25)
         return CTRL_W'(((17'h4000 - fa_reg) >> 1) + $urandom_range(0, 1));
      if (r < 32) return '0;
      if (r < 40) return '1;
      return CTRL_W'($urandom);
   endfunction

   function automatic logic [CTRL_W-1:0] pick_density();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return CTRL_W'($urandom);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return SAMPLE_BITS'(SAMPLE_MAX);
      if (r < 16) return SAMPLE_BITS'(SAMPLE_MIN);
      if (r < 24) return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type typed_frame);
      rsp_word_type p;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      p = smooth_and_scale(w);
      frames_due.push_back(typed ? typed_frame : p);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CTRL_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FUNCTION_AMOUNT: fa_reg = v;
         CSR_SUSTAIN_CUT:     cut_reg = v;
         CSR_RAMP_STEPS:      steps_reg = v;
         default: ;
      endcase
   endtask

   // result side back-pressure
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      forever begin
         if ($urandom_range(0, 99) < 10) begin
            run = $urandom_range(100, 400);
            stall = 0;
         end else begin
            run = $urandom_range(1, 8);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(1, 3);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (run - 1) @(negedge clock);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: %h %h %h",
                        rsp_word.out_ch0, rsp_word.out_ch1, rsp_word.gain_now);
         end else begin
            want = frames_due.pop_front();
            if (rsp_word.out_ch0 !== want.out_ch0 || rsp_word.out_ch1 !== want.out_ch1 ||
                rsp_word.gain_now !== want.gain_now) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: ch0 %h/%h ch1 %h/%h gain %h/%h (expected/actual)",
                           want.out_ch0, rsp_word.out_ch0, want.out_ch1, rsp_word.out_ch1,
                           want.gain_now, rsp_word.gain_now);
            end
         end
      end
   end

   initial begin
      plan_row_type row;
      req_word_type w;
      logic [CTRL_W-1:0] inten;
      logic [CTRL_W-1:0] dens;
      logic steady;

      mismatches = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FUNCTION_AMOUNT;
      csr_data = '0;
      fa_reg = '0;
      cut_reg = '0;
      steps_reg = RAMP_STEPS_RST;
      cur_gain = ONE_Q28;
      tgt_gain = ONE_Q28;
      ramp_inc = '0;
      ramp_count = '0;
      inten = '0;
      dens = '0;

      // reset values: gate with no cut is unity gain
      plan_check(0, 0, 32'h7FFFFF, -32'h800000, 32'h7FFFFF, -32'h800000, ONE_Q28);
      plan_check(16'hFFFF, 0, 0, -1, 0, -1, ONE_Q28);
      plan_csr(CSR_UNUSED, 16'hFFFF);
      plan_check(0, 0, 1, 1, 1, 1, ONE_Q28);
      // immediate jumps, expansion extremes
      plan_csr(CSR_RAMP_STEPS, 0);
      plan_csr(CSR_FUNCTION_AMOUNT, 16'h4000);
      plan_check(0, 0, 2, -2, 1, -1, HALF_Q28);
      plan_check(16'hFFFF, 0, 32'h7FFFFF, -32'h800000, 32'h7FFFFF, -32'h800000, 32'h27FFE000);
      plan_word(16'hFFFF, 16'hFFFF, 32'h123456, -32'h654321);
      // gate threshold edges
      plan_csr(CSR_SUSTAIN_CUT, 16'hFFFF);
      plan_csr(CSR_FUNCTION_AMOUNT, 16'h3FFF);
      plan_word(0, 0, 32'h7FFFFF, 32'h7FFFFF);
      plan_check(1, 0, 0, 0, 0, 0, ONE_Q28);
      plan_csr(CSR_FUNCTION_AMOUNT, 0);
      plan_word(16'h2000, 0, 32'h7FFFFF, -32'h800000);
      plan_word(16'h2001, 16'h1234, 32'h400000, -32'h3);
      // compression
      plan_csr(CSR_FUNCTION_AMOUNT, 16'h8000);
      plan_check(0, 0, 5, -5, 5, -5, ONE_Q28);
      plan_word(16'hFFFF, 16'h8000, 32'h7FFFFF, -32'h800000);
      plan_csr(CSR_FUNCTION_AMOUNT, 16'hBFFF);
      plan_word(16'h7FFF, 0, 32'h2AAAAA, -32'h155555);
      // inversion
      plan_csr(CSR_FUNCTION_AMOUNT, 16'hC000);
      plan_check(0, 0, 100, -100, 100, -100, ONE_Q28);
      plan_word(16'hFFFF, 0, 32'h7FFFFF, -32'h800000);
      plan_csr(CSR_FUNCTION_AMOUNT, 16'hFFFF);
      plan_word(16'hFFFF, 16'hFFFF, -32'h800000, 32'h7FFFFF);
      // ramp start, continuation, length change mid ramp
      plan_csr(CSR_RAMP_STEPS, 4);
      plan_csr(CSR_FUNCTION_AMOUNT, 16'h4000);
      plan_word(0, 0, 32'h7FFFFF, -32'h800000);
      plan_word(0, 0, 32'h7FFFFF, -32'h800000);
      plan_csr(CSR_RAMP_STEPS, 16'hFFFF);
      plan_word(0, 0, 32'h7FFFFF, -32'h800000);
      plan_word(0, 0, 32'h7FFFFF, -32'h800000);
      plan_word(16'hFFFF, 0, 32'h100000, -32'h100000);
      plan_word(16'hFFFF, 0, 32'h100000, -32'h100000);
      plan_csr(CSR_RAMP_STEPS, 1);
      plan_word(16'h8000, 0, 32'h100000, -32'h100000);
      plan_word(16'h8000, 0, 32'h100000, -32'h100000);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         row = plan[n];
         if (row.kind == STEP_CSR) begin
            wait_idle();
            write_reg(row.idx, row.data);
         end else begin
            send_word(row.word, row.typed, row.frame);
            idle_gap(gap_len());
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         write_reg(CSR_FUNCTION_AMOUNT, pick_amount());
         write_reg(CSR_SUSTAIN_CUT, pick_cut());
         write_reg(CSR_RAMP_STEPS, (ph == 5) ? 16'hFFFF : pick_steps());
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, CTRL_W'($urandom));
         steady = (ph % 4 == 0);
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            // repeated controls keep the target steady so ramps run out
            if (k == 0 || $urandom_range(0, 99) < 45) begin
               inten = pick_intensity();
               dens = pick_density();
            end
            w.intensity = inten;
            w.density = dens;
            w.sample_ch0 = pick_sample();
            w.sample_ch1 = pick_sample();
            send_word(w, 1'b0, '0);
            if ($urandom_range(0, 99) == 0) wait_idle();
            else if (!steady) idle_gap(gap_len());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/msg_pkg.sv
hw/rtl/msg_div.sv
hw/rtl/msg_mul.sv
hw/rtl/mode_select_gain_with_ramp_smoothing_unit.sv
tb/sv/tb_top.sv
